// ===== src/complex_to_scaled_amplitude_assert.svh =====
// Assertion macros for the RTL.
`ifndef COMPLEX_TO_SCALED_AMPLITUDE_ASSERT_SVH
`define COMPLEX_TO_SCALED_AMPLITUDE_ASSERT_SVH

// Checked at every rising clock edge; the check is dropped while rst is high.
`define CTSA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ctsa assertion failed");

// Checked at every rising clock edge, reset included.
`define CTSA_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("ctsa assertion failed");

`endif

// ===== src/ctsa_pkg.sv =====
`default_nettype none

package ctsa_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int MAG_W        = SAMPLE_WIDTH;       // |sample| fits unsigned
   localparam int SUM_W        = 2 * MAG_W;          // re^2 + im^2
   localparam int ROOT_W       = SUM_W / 2;          // floor sqrt width
   localparam int REM_W        = ROOT_W + 2;         // sqrt remainder
   localparam int OVERLAP_W    = 7;
   localparam int FRAME_W      = 5;
   localparam int AMP_W        = 30;
   localparam int PROD_W       = ROOT_W + OVERLAP_W;
   localparam int WIDE_W       = PROD_W + AMP_W;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = OVERLAP_W;

   // front end 3 stages, one per root bit, scaler 2 stages
   localparam int LATENCY      = 3 + ROOT_W + 2;

   localparam logic [AMP_W-1:0]     AMP_MAX       = {AMP_W{1'b1}};
   localparam logic [OVERLAP_W-1:0] OVERLAP_RESET = OVERLAP_W'(1);
   localparam logic [FRAME_W-1:0]   FRAME_RESET   = FRAME_W'(6);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OVERLAP = CSR_INDEX_W'(0),
      CSR_FRAME   = CSR_INDEX_W'(1)
   } csr_index_type;

   // Data handed from one square root cell to the next.
   typedef struct packed {
      logic              valid;
      logic [SUM_W-1:0]  rad;    // radicand bits not yet consumed, MSB first
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_stage_type;

endpackage

`default_nettype wire

// ===== src/ctsa_sumsq.sv =====
`default_nettype none

module ctsa_sumsq (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  accept,
   input  wire logic signed [ctsa_pkg::SAMPLE_WIDTH-1:0] real_part,
   input  wire logic signed [ctsa_pkg::SAMPLE_WIDTH-1:0] imag_part,
   output ctsa_pkg::sqrt_stage_type                   stage_out
);

   logic                          v0_ff, v1_ff, v2_ff;
   logic [ctsa_pkg::MAG_W-1:0]    re_mag_ff, im_mag_ff;
   logic [ctsa_pkg::MAG_W-1:0]    re_mag_in, im_mag_in;
   logic [ctsa_pkg::SUM_W-1:0]    re_sq_ff, im_sq_ff, sum_ff;

   // two's complement magnitude; the most negative value maps to 2^(W-1)
   always_comb begin
      re_mag_in = real_part[ctsa_pkg::SAMPLE_WIDTH-1] ?
                  ctsa_pkg::MAG_W'(~real_part + 1'b1) : ctsa_pkg::MAG_W'(real_part);
      im_mag_in = imag_part[ctsa_pkg::SAMPLE_WIDTH-1] ?
                  ctsa_pkg::MAG_W'(~imag_part + 1'b1) : ctsa_pkg::MAG_W'(imag_part);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      re_mag_ff <= re_mag_in;
      im_mag_ff <= im_mag_in;
      re_sq_ff  <= ctsa_pkg::SUM_W'(re_mag_ff) * ctsa_pkg::SUM_W'(re_mag_ff);
      im_sq_ff  <= ctsa_pkg::SUM_W'(im_mag_ff) * ctsa_pkg::SUM_W'(im_mag_ff);
      sum_ff    <= re_sq_ff + im_sq_ff;
   end

   always_comb begin
      stage_out.valid = v2_ff;
      stage_out.rad   = sum_ff;
      stage_out.rem   = '0;
      stage_out.root  = '0;
   end

endmodule

`default_nettype wire

// ===== src/ctsa_sqrt_cell.sv =====
`default_nettype none

// One restoring square root step: consumes two radicand bits, yields one root bit.
module ctsa_sqrt_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctsa_pkg::sqrt_stage_type stage_in,
   output ctsa_pkg::sqrt_stage_type      stage_out
);

   logic [ctsa_pkg::REM_W+1:0] acc;
   logic [ctsa_pkg::REM_W+1:0] trial;
   logic [ctsa_pkg::REM_W+1:0] diff;
   logic                       take;
   logic                       valid_ff;
   ctsa_pkg::sqrt_stage_type   data_ff, data_in;

   always_comb begin
      acc   = {stage_in.rem, stage_in.rad[ctsa_pkg::SUM_W-1 -: 2]};
      trial = (ctsa_pkg::REM_W + 2)'({stage_in.root, 2'b01});
      diff  = acc - trial;
      take  = (acc >= trial);
      data_in       = stage_in;
      data_in.valid = stage_in.valid;
      data_in.rad   = stage_in.rad << 2;
      data_in.rem   = take ? diff[ctsa_pkg::REM_W-1:0] : acc[ctsa_pkg::REM_W-1:0];
      data_in.root  = {stage_in.root[ctsa_pkg::ROOT_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      stage_out       = data_ff;
      stage_out.valid = valid_ff;
   end

endmodule

`default_nettype wire

// ===== src/ctsa_scale.sv =====
`default_nettype none

module ctsa_scale (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ctsa_pkg::sqrt_stage_type          stage_in,
   input  wire logic [ctsa_pkg::OVERLAP_W-1:0]    overlap_factor,
   input  wire logic [ctsa_pkg::FRAME_W-1:0]      frame_log2,
   output logic                                   amp_valid,
   output logic [ctsa_pkg::AMP_W-1:0]             amplitude
);

   logic [ctsa_pkg::OVERLAP_W-1:0] ov;
   logic                           pv_ff, av_ff;
   logic [ctsa_pkg::PROD_W-1:0]    prod_ff;
   logic [ctsa_pkg::PROD_W-1:0]    shifted;
   logic [ctsa_pkg::WIDE_W-1:0]    wide;
   logic [ctsa_pkg::AMP_W-1:0]     amp_ff, amp_in;

   // overlap of zero counts as one
   assign ov = (overlap_factor == '0) ? ctsa_pkg::OVERLAP_W'(1) : overlap_factor;

   always_comb begin
      shifted = prod_ff >> frame_log2;
      wide    = ctsa_pkg::WIDE_W'(shifted);
      amp_in  = (|wide[ctsa_pkg::WIDE_W-1:ctsa_pkg::AMP_W]) ?
                ctsa_pkg::AMP_MAX : wide[ctsa_pkg::AMP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         av_ff <= 1'b0;
      end else begin
         pv_ff <= stage_in.valid;
         av_ff <= pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= ctsa_pkg::PROD_W'(stage_in.root) * ctsa_pkg::PROD_W'(ov);
      amp_ff  <= amp_in;
   end

   assign amp_valid = av_ff;
   assign amplitude = amp_ff;

endmodule

`default_nettype wire

// ===== src/complex_to_scaled_amplitude.sv =====
// complex_to_scaled_amplitude
//
// Turns one complex spectral bin into a scaled amplitude:
//   rsp_amplitude = min(2^30-1, (floor(sqrt(re^2 + im^2)) * overlap) >> frame_log2)
// with an overlap of zero treated as one.
//
// Input: a bin is taken on each rising edge with start high and busy low.
// busy is high only while reset is held, so one bin per cycle streams in.
// Output: rsp_valid strobes for one cycle with rsp_amplitude; there is no
// back pressure, the receiver must take every result as it comes.
// Pipeline stages in order: abs, square, sum, then one cell per root bit,
// then multiply and shift/saturate.
// Throughput is one bin per cycle outside reset; the root is computed by a chain of cells,
// each resolving one bit per cycle.
// CSR port: csr_valid/csr_ready with csr_index (0 overlap, 1 frame_log2) and
// csr_wdata; writes to other indexes are dropped. csr_ready is always high.
// Write registers only while no bins are in flight.
// Reset (synchronous) empties the pipeline and loads overlap 1, frame_log2 6.

`default_nettype none

`include "complex_to_scaled_amplitude_assert.svh"

module complex_to_scaled_amplitude (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire logic signed [ctsa_pkg::SAMPLE_WIDTH-1:0] req_real_part,
   input  wire logic signed [ctsa_pkg::SAMPLE_WIDTH-1:0] req_imag_part,
   output logic                                          rsp_valid,
   output logic [ctsa_pkg::AMP_W-1:0]                    rsp_amplitude,
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic [ctsa_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire logic [ctsa_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   logic                           accept;
   logic [ctsa_pkg::OVERLAP_W-1:0] overlap_ff, overlap_in;
   logic [ctsa_pkg::FRAME_W-1:0]   frame_ff, frame_in;

   // stage[0] from the squaring front end, stage[ROOT_W] holds the full root
   ctsa_pkg::sqrt_stage_type stage [0:ctsa_pkg::ROOT_W];

   assign busy      = reset;
   assign accept    = start & ~busy;
   assign csr_ready = 1'b1;

   // configuration registers
   always_comb begin
      overlap_in = overlap_ff;
      frame_in   = frame_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ctsa_pkg::CSR_OVERLAP: overlap_in = csr_wdata[ctsa_pkg::OVERLAP_W-1:0];
            ctsa_pkg::CSR_FRAME:   frame_in   = csr_wdata[ctsa_pkg::FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overlap_ff <= ctsa_pkg::OVERLAP_RESET;
         frame_ff   <= ctsa_pkg::FRAME_RESET;
      end else begin
         overlap_ff <= overlap_in;
         frame_ff   <= frame_in;
      end
   end

   // |re|, |im|, squares, sum
   ctsa_sumsq u_sumsq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .real_part (req_real_part),
      .imag_part (req_imag_part),
      .stage_out (stage[0])
   );

   // square root: one cell per root bit, MSB first
   for (genvar i = 0; i < ctsa_pkg::ROOT_W; i++) begin : g_cell
      ctsa_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage[i]),
         .stage_out (stage[i+1])
      );
   end

   // overlap multiply, frame shift, saturate
   ctsa_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .stage_in       (stage[ctsa_pkg::ROOT_W]),
      .overlap_factor (overlap_ff),
      .frame_log2     (frame_ff),
      .amp_valid      (rsp_valid),
      .amplitude      (rsp_amplitude)
   );

   // every accepted bin gives a result, and every result had an accepted bin
   `CTSA_ASSERT(a_rsp_after_req, clock, reset, accept |-> ##(ctsa_pkg::LATENCY) rsp_valid)
   `CTSA_ASSERT(a_rsp_has_req, clock, reset, rsp_valid |-> $past(accept, ctsa_pkg::LATENCY))
   // a zero bin gives a zero amplitude
   `CTSA_ASSERT(a_zero_bin, clock, reset, rsp_valid && $past(req_real_part == '0 && req_imag_part == '0, ctsa_pkg::LATENCY) |-> rsp_amplitude == '0)
   // pipeline is empty the cycle after reset
   `CTSA_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_valid)

endmodule

`default_nettype wire

// ===== sim/amplitude_checker.sv =====
`default_nettype none

module amplitude_checker
   import ctsa_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic                           busy,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_real_part,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_imag_part,
   input  wire logic                           rsp_valid,
   input  wire logic [AMP_W-1:0]               rsp_amplitude,
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]          csr_wdata,
   output int                                  mismatches,
   output int                                  outstanding,
   output int                                  checked
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_LIMIT = 25;

   typedef struct {
      int unsigned      bin_no;
      logic [AMP_W-1:0] amplitude;
   } owed_amplitude_type;

   owed_amplitude_type owed_amplitudes[$];
   logic [OVERLAP_W-1:0] overlap;
   logic [FRAME_W-1:0]   frame_shift;
   int unsigned          bins_seen;

   initial begin
      mismatches  = 0;
      outstanding = 0;
      checked     = 0;
      bins_seen   = 0;
   end

   function automatic logic [63:0] floor_sqrt(logic [63:0] radicand);
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] probe;
      rest  = radicand;
      root  = '0;
      probe = 64'd1 << 62;
      while (probe > rest)
         probe >>= 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic logic [AMP_W-1:0] predict_amplitude(
      logic signed [SAMPLE_WIDTH-1:0] re,
      logic signed [SAMPLE_WIDTH-1:0] im,
      logic [OVERLAP_W-1:0]           ov,
      logic [FRAME_W-1:0]             shift
   );
      logic signed [63:0] wide_re;
      logic signed [63:0] wide_im;
      logic [63:0]        abs_re;
      logic [63:0]        abs_im;
      logic [63:0]        scaled;
      logic [63:0]        gain;
      wide_re = re;
      wide_im = im;
      abs_re  = (wide_re < 0) ? -wide_re : wide_re;
      abs_im  = (wide_im < 0) ? -wide_im : wide_im;
      // overlap of zero behaves as one
      gain    = (ov == '0) ? 64'd1 : 64'(ov);
      scaled  = (floor_sqrt(abs_re * abs_re + abs_im * abs_im) * gain) >> shift;
      if (scaled > 64'(AMP_MAX))
         scaled = 64'(AMP_MAX);
      return scaled[AMP_W-1:0];
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatches < PRINT_LIMIT)
         $display("[%0t] amplitude check: %s", $realtime, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      owed_amplitude_type owed;
      if (reset) begin
         overlap     = OVERLAP_RESET;
         frame_shift = FRAME_RESET;
         owed_amplitudes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OVERLAP: overlap = csr_wdata;
               CSR_FRAME:   frame_shift = csr_wdata[FRAME_W-1:0];
               default: ;
            endcase
         end
         // retire before accepting so a stray result is never masked
         if (rsp_valid) begin
            if (owed_amplitudes.size() == 0) begin
               report_mismatch($sformatf("amplitude %0d with no bin in flight",
                                         rsp_amplitude));
            end else begin
               owed = owed_amplitudes.pop_front();
               checked++;
               if (rsp_amplitude !== owed.amplitude)
                  report_mismatch($sformatf("bin %0d gave %0d, predicted %0d",
                                            owed.bin_no, rsp_amplitude,
                                            owed.amplitude));
            end
         end
         if (start && !busy) begin
            owed.bin_no    = bins_seen;
            owed.amplitude = predict_amplitude(req_real_part, req_imag_part,
                                               overlap, frame_shift);
            owed_amplitudes.push_back(owed);
            bins_seen++;
         end
      end
      outstanding <= owed_amplitudes.size();
   end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import ctsa_pkg::*;

   // Run shape: random phases, each with its own register setting.
   localparam int RANDOM_PHASES  = 10;
   localparam int BINS_PER_PHASE = 195;
   localparam int DRAIN_LIMIT    = 20 * LATENCY + 1000;
   // Hard stop for the whole run, in ns.
   localparam int TIMEOUT_NS     = 2_000_000;

   // Indexes the block must ignore.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = CSR_INDEX_W'(3);

   localparam logic signed [SAMPLE_WIDTH-1:0] PART_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] PART_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

   // Fixed settings for the first random phases: reset value, saturation
   // corner, zero overlap with a masked frame write (7'h7F -> 31), the
   // top of the stated ranges, and two odd ones. Later phases pick at random.
   localparam logic [CSR_DATA_W-1:0] PHASE_OVERLAP [6] =
      '{7'd1, 7'd127, 7'd0, 7'd64, 7'd3, 7'd100};
   localparam logic [CSR_DATA_W-1:0] PHASE_FRAME [6] =
      '{7'd6, 7'd0, 7'h7F, 7'd16, 7'd1, 7'd23};

   // Sender idle percentage, cycled over the phases. The result side has
   // no back pressure, so only the sender idles.
   localparam int SENDER_IDLE_PCT [3] = '{0, 50, 37};

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic signed [SAMPLE_WIDTH-1:0] req_real_part = '0;
   logic signed [SAMPLE_WIDTH-1:0] req_imag_part = '0;
   logic                           rsp_valid;
   logic [AMP_W-1:0]               rsp_amplitude;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [CSR_INDEX_W-1:0]         csr_index = CSR_OVERLAP;
   logic [CSR_DATA_W-1:0]          csr_wdata = '0;

   int mismatches;
   int outstanding;
   int checked;
   int bins_sent    = 0;
   int settings_run = 0;

   complex_to_scaled_amplitude dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_real_part (req_real_part),
      .req_imag_part (req_imag_part),
      .rsp_valid     (rsp_valid),
      .rsp_amplitude (rsp_amplitude),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // Watches all three channels, predicts each amplitude and compares.
   amplitude_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_real_part (req_real_part),
      .req_imag_part (req_imag_part),
      .rsp_valid     (rsp_valid),
      .rsp_amplitude (rsp_amplitude),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .checked       (checked)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Random bin component. Extremes and tiny values come up often so that
   // large frame shifts still leave nonzero amplitudes to look at; the
   // arithmetic shift spreads magnitudes over the whole range.
   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_part();
      logic signed [SAMPLE_WIDTH-1:0] raw;
      raw = SAMPLE_WIDTH'($urandom());
      case ($urandom_range(0, 7))
         0: return PART_MIN;
         1: return PART_MAX;
         2: return SAMPLE_WIDTH'($urandom_range(0, 31)) - SAMPLE_WIDTH'(16);
         3, 4: return raw >>> $urandom_range(0, SAMPLE_WIDTH - 2);
         default: return raw;
      endcase
   endfunction

   // One bin transfer. start is left high so the next bin can follow in
   // the very next cycle; whoever idles the sender lowers it.
   task automatic send_bin(logic signed [SAMPLE_WIDTH-1:0] re,
                           logic signed [SAMPLE_WIDTH-1:0] im);
      start         <= 1'b1;
      req_real_part <= re;
      req_imag_part <= im;
      do @(posedge clock); while (busy);
      bins_sent++;
   endtask

   // Geometric run of idle cycles: on average pct percent of cycles idle.
   task automatic sender_gap(int pct);
      if ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < pct);
      end
   endtask

   // Hold the sender off until every owed amplitude has come back. The
   // first edge lets the checker count a bin taken in this same cycle.
   task automatic drain_pipeline();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Leaves csr_valid high so back-to-back writes need no extra cycle.
   task automatic write_register(logic [CSR_INDEX_W-1:0] idx,
                                 logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Registers only change with the pipeline empty. Optionally pokes the
   // unmapped indexes too, which must leave the setting untouched.
   task automatic set_config(logic [CSR_DATA_W-1:0] ov,
                             logic [CSR_DATA_W-1:0] frame_data,
                             bit poke_unmapped);
      drain_pipeline();
      write_register(CSR_OVERLAP, ov);
      write_register(CSR_FRAME, frame_data);
      if (poke_unmapped) begin
         write_register(CSR_UNMAPPED_LO, CSR_DATA_W'($urandom()));
         write_register(CSR_UNMAPPED_HI, CSR_DATA_W'($urandom()));
      end
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] ov_data;
      logic [CSR_DATA_W-1:0] frame_data;
      int                    idle_pct;
      bit                    quiet;
      int                    tail;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset setting (overlap 1, shift 6), field extremes,
      // zero bin, most negative parts on both axes.
      send_bin(0, 0);
      send_bin(PART_MAX, PART_MAX);
      send_bin(PART_MIN, PART_MIN);
      send_bin(PART_MIN, PART_MAX);
      send_bin(PART_MAX, PART_MIN);
      send_bin(-1, -1);
      send_bin(3, -4);
      send_bin(PART_MIN, 0);
      send_bin(0, 1);

      // Largest overlap with no shift: a bin at full scale on both axes saturates the output.
      set_config(7'd127, 7'd0, 1'b1);
      send_bin(PART_MIN, PART_MIN);
      send_bin(PART_MAX, 0);
      send_bin(-5, 12);

      // Zero overlap counts as one; frame write with upper bits set (-> 0).
      set_config(7'd0, 7'h60, 1'b0);
      send_bin(3, 4);
      send_bin(PART_MIN, PART_MAX);
      send_bin(-1, 0);

      // Top of the documented ranges.
      set_config(7'd64, 7'd16, 1'b0);
      send_bin(PART_MIN, PART_MIN);
      send_bin(PART_MAX, PART_MAX);
      send_bin(100, -100);

      // Largest shift: everything truncates to zero.
      set_config(7'd127, 7'h1F, 1'b1);
      send_bin(PART_MIN, PART_MIN);

      // Random phases. Each one drains first, so the sender fully pauses
      // for owed results at every setting change.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 6) begin
            ov_data    = PHASE_OVERLAP[phase];
            frame_data = PHASE_FRAME[phase];
         end else begin
            ov_data    = CSR_DATA_W'($urandom_range(0, 127));
            frame_data = CSR_DATA_W'($urandom_range(0, 127));
         end
         set_config(ov_data, frame_data, phase % 2 == 1);
         idle_pct = SENDER_IDLE_PCT[phase % 3];
         quiet    = 1'b0;
         for (int k = 0; k < BINS_PER_PHASE; k++) begin
            // now and then a burst with no idling even in a gappy phase
            if (k % 40 == 0)
               quiet = ($urandom_range(0, 3) == 0);
            if (!quiet)
               sender_gap(idle_pct);
            send_bin(pick_part(), pick_part());
         end
      end

      // Wind down: wait for the owed amplitudes, then a pipeline's worth
      // more to catch anything extra coming out.
      start <= 1'b0;
      @(posedge clock);
      for (tail = 0; tail < DRAIN_LIMIT && outstanding != 0; tail++)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      if (outstanding != 0)
         $display("%0d amplitudes never came back", outstanding);
      $display("covered %0d bins over %0d register settings (overlap 0..127,",
               bins_sent, settings_run);
      $display("  shift 0..31, masked and unmapped writes), sender idle 0/37/50%%;"
               , " %0d amplitudes compared", checked);
      if (mismatches == 0 && outstanding == 0) begin
         $display("complex_to_scaled_amplitude regression: pass");
      end else begin
         $display("complex_to_scaled_amplitude regression: fail");
      end
      $finish;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #(TIMEOUT_NS);
      $display("timeout after %0d ns", TIMEOUT_NS);
      $display("complex_to_scaled_amplitude regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/ctsa_pkg.sv
src/ctsa_sumsq.sv
src/ctsa_sqrt_cell.sv
src/ctsa_scale.sv
src/complex_to_scaled_amplitude.sv
sim/amplitude_checker.sv
sim/tb_top.sv
